@@ rtl/erq_pkg.sv @@
// ----------------------------------------------------------------------------
// erq_pkg
// Shared widths, register indexes and item types for the eps region query.
// ----------------------------------------------------------------------------
package erq_pkg;

    localparam int ID_W           = 32;
    localparam int EPS_W          = 52;
    localparam int CFG_DATA_W     = 52;
    localparam int CFG_IDX_W      = 3;
    localparam int DEF_DIMENSIONS = 3;
    localparam int DEF_COORD_BITS = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_QUERY_X     = 3'd0,
        REG_QUERY_Y     = 3'd1,
        REG_QUERY_Z     = 3'd2,
        REG_EPS_SQUARED = 3'd3,
        REG_QUERY_INDEX = 3'd4
    } cfg_reg_t;

    // per-candidate fields that ride along the pipeline
    typedef struct packed {
        logic [ID_W-1:0] index;
        logic [ID_W-1:0] cluster;
        logic            assigned;
        logic            core;
        logic            last;
    } item_meta_t;

    typedef struct packed {
        logic            in_range;
        logic [ID_W-1:0] hit_index;
        logic [ID_W-1:0] cluster_id;
        logic            last;
    } result_t;

endpackage

@@ rtl/erq_dist.sv @@
// ----------------------------------------------------------------------------
// erq_dist
// Squared coordinate difference per dimension, one registered stage.
// ----------------------------------------------------------------------------
module erq_dist
    import erq_pkg::*;
#(
    parameter int DIMENSIONS = DEF_DIMENSIONS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  coord [DIMENSIONS],
    input  logic signed [COORD_BITS-1:0]  query [DIMENSIONS],
    input  item_meta_t                    in_meta,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2*(COORD_BITS+1)-1:0]   square [DIMENSIONS],
    output item_meta_t                    out_meta
);

    localparam int DW = COORD_BITS + 1;

    logic                valid_reg;
    logic [2*DW-1:0]     sq_reg [DIMENSIONS];
    logic [2*DW-1:0]     sq_next [DIMENSIONS];
    item_meta_t          meta_reg;
    logic                en;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;

    always_comb begin
        logic signed [DW-1:0] diff;
        logic [DW-1:0]        mag;
        for (int d = 0; d < DIMENSIONS; d++) begin
            diff = DW'(coord[d]) - DW'(query[d]);
            mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
            sq_next[d] = (2*DW)'(mag) * (2*DW)'(mag);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && in_valid) begin
            sq_reg   <= sq_next;
            meta_reg <= in_meta;
        end
    end

    assign out_valid = valid_reg;
    assign square    = sq_reg;
    assign out_meta  = meta_reg;

endmodule

@@ rtl/erq_track.sv @@
// ----------------------------------------------------------------------------
// erq_track
// Distance sum and radius test, running minimum cluster id, result register.
// ----------------------------------------------------------------------------
module erq_track
    import erq_pkg::*;
#(
    parameter int DIMENSIONS = DEF_DIMENSIONS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2*(COORD_BITS+1)-1:0]   square [DIMENSIONS],
    input  item_meta_t                    in_meta,
    input  logic [EPS_W-1:0]              eps_squared,
    input  logic [ID_W-1:0]               query_index,
    output logic                          out_valid,
    input  logic                          out_ready,
    output result_t                       result
);

    localparam int SQ_W  = 2 * (COORD_BITS + 1);
    localparam int SUM_W = SQ_W + 2;
    localparam int CMP_W = (SUM_W > EPS_W) ? SUM_W : EPS_W;

    logic             valid_reg;
    logic             start_reg;
    logic [ID_W-1:0]  best_reg;
    logic [ID_W-1:0]  best_next;
    result_t          res_reg;
    result_t          res_next;
    logic [SUM_W-1:0] sq_sum;
    logic             hit;
    logic [ID_W-1:0]  base;
    logic             en;
    logic             take;

    assign en       = !valid_reg || out_ready;
    assign in_ready = en;
    assign take     = en && in_valid;

    always_comb begin
        sq_sum = '0;
        for (int d = 0; d < DIMENSIONS; d++) begin
            sq_sum = sq_sum + SUM_W'(square[d]);
        end
    end

    assign hit  = CMP_W'(sq_sum) <= CMP_W'(eps_squared);
    assign base = start_reg ? query_index + ID_W'(1) : best_reg;

    always_comb begin
        best_next = base;
        if (hit && in_meta.assigned && in_meta.core && (in_meta.cluster < base)) begin
            best_next = in_meta.cluster;
        end
        res_next.in_range   = hit;
        res_next.hit_index  = in_meta.index;
        res_next.cluster_id = best_next;
        res_next.last       = in_meta.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            start_reg <= 1'b1;
        end else begin
            if (en) begin
                valid_reg <= in_valid;
            end
            if (take) begin
                start_reg <= in_meta.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_reg <= best_next;
            res_reg  <= res_next;
        end
    end

    assign out_valid = valid_reg;
    assign result    = res_reg;

endmodule

@@ rtl/eps_region_query.sv @@
// ----------------------------------------------------------------------------
// eps_region_query
// Epsilon-neighborhood test of streamed candidates against a query point,
// with a running minimum cluster id over in-range assigned core neighbors.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    tdata, tuser, tlast (candidate)
//   m_       out  m_tvalid/m_tready    tdata, tuser, tlast (result)
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//
// One word per cycle sustained while m_tready is high; the result word passes
// through the input register, square register and result register in turn.
// Reset (synchronous, aresetn low) empties the pipeline, clears the configuration
// registers and starts a fresh query. Each stage holds while the next is full and
// stalled, so a bubble is filled while m_tready is low.
// ----------------------------------------------------------------------------
module eps_region_query
    import erq_pkg::*;
#(
    parameter int DIMENSIONS = DEF_DIMENSIONS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // coord_x, coord_y, coord_z, neighbor_index, neighbor_cluster, zero pad
    input  logic [((3*COORD_BITS+2*ID_W+7)/8)*8-1:0] s_tdata,
    // neighbor_assigned, neighbor_core
    input  logic [1:0]            s_tuser,
    input  logic                  s_tlast,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // hit_index, cluster_id
    output logic [2*ID_W-1:0]     m_tdata,
    // in_range
    output logic [0:0]            m_tuser,
    output logic                  m_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int META_LSB = 3 * COORD_BITS;

    logic signed [COORD_BITS-1:0] qc_reg [DIMENSIONS];
    logic [EPS_W-1:0]             eps_reg;
    logic [ID_W-1:0]              qidx_reg;

    logic                         v1_reg;
    logic signed [COORD_BITS-1:0] coord_reg [DIMENSIONS];
    item_meta_t                   meta1_reg;
    item_meta_t                   meta1_next;
    logic                         en1;

    logic                         dist_ready;
    logic                         v2;
    logic [2*(COORD_BITS+1)-1:0]  square [DIMENSIONS];
    item_meta_t                   meta2;
    logic                         track_ready;
    result_t                      result;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < DIMENSIONS; d++) begin
                qc_reg[d] <= '0;
            end
            eps_reg  <= '0;
            qidx_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_EPS_SQUARED: eps_reg  <= cfg_data[EPS_W-1:0];
                REG_QUERY_INDEX: qidx_reg <= cfg_data[ID_W-1:0];
                default: begin
                    for (int d = 0; d < DIMENSIONS; d++) begin
                        if (cfg_index == CFG_IDX_W'(REG_QUERY_X) + CFG_IDX_W'(d)) begin
                            qc_reg[d] <= cfg_data[COORD_BITS-1:0];
                        end
                    end
                end
            endcase
        end
    end

    // input register
    assign en1      = !v1_reg || dist_ready;
    assign s_tready = en1;

    always_comb begin
        meta1_next.index    = s_tdata[META_LSB +: ID_W];
        meta1_next.cluster  = s_tdata[META_LSB+ID_W +: ID_W];
        meta1_next.assigned = s_tuser[0];
        meta1_next.core     = s_tuser[1];
        meta1_next.last     = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_tvalid) begin
            for (int d = 0; d < DIMENSIONS; d++) begin
                coord_reg[d] <= s_tdata[d*COORD_BITS +: COORD_BITS];
            end
            meta1_reg <= meta1_next;
        end
    end

    erq_dist #(
        .DIMENSIONS (DIMENSIONS),
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_ready  (dist_ready),
        .coord     (coord_reg),
        .query     (qc_reg),
        .in_meta   (meta1_reg),
        .out_valid (v2),
        .out_ready (track_ready),
        .square    (square),
        .out_meta  (meta2)
    );

    erq_track #(
        .DIMENSIONS (DIMENSIONS),
        .COORD_BITS (COORD_BITS)
    ) u_track (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v2),
        .in_ready    (track_ready),
        .square      (square),
        .in_meta     (meta2),
        .eps_squared (eps_reg),
        .query_index (qidx_reg),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result      (result)
    );

    assign m_tdata = {result.cluster_id, result.hit_index};
    assign m_tuser = result.in_range;
    assign m_tlast = result.last;

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for eps_region_query. Candidate words stream in with
// random gaps while the result side stalls at random. Each accepted candidate
// is run through a local neighborhood predictor (exact squared distance,
// running minimum cluster id per query); results are checked field by field
// in order. A short directed table covers the extremes first, then random
// phases reprogram the query point, radius and index and send queries of
// random length.
// ----------------------------------------------------------------------------
module tb_top;
    import erq_pkg::*;

    localparam int CW          = DEF_COORD_BITS;
    localparam int SD_W        = ((3*CW + 2*ID_W + 7)/8)*8;
    localparam int ITEM_TARGET = 1950;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam logic [EPS_W-1:0] EPS_MAX = {EPS_W{1'b1}};

    typedef struct packed {
        logic [2:0][CW-1:0] coord;
        logic [ID_W-1:0]    index;
        logic [ID_W-1:0]    cluster;
        logic               assigned;
        logic               core;
        logic               last;
    } cand_t;

    typedef struct packed {
        logic                  is_cfg;
        cfg_reg_t              cfg_sel;
        logic [CFG_DATA_W-1:0] cfg_val;
        cand_t                 cand;
        logic                  typed_in;
        result_t               want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic [SD_W-1:0]       s_tdata;
    logic [1:0]            s_tuser;
    logic                  s_tlast;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [2*ID_W-1:0]     m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predictor state
    logic [2:0][CW-1:0]    q_coord;
    logic [EPS_W-1:0]      eps_thr;
    logic [ID_W-1:0]       q_index;
    logic [ID_W-1:0]       best_id;
    logic                  new_query;

    result_t pending_results[$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    int      ready_hold  = 0;
    int      idle_cycles = 0;
    logic    src_calm    = 1'b0;
    logic    sink_calm   = 1'b0;

    eps_region_query DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap(input logic calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic result_t predict_neighbor(input cand_t c);
        result_t         r;
        longint          diff;
        longint unsigned mag;
        longint unsigned sqdist;
        if (new_query) best_id = q_index + 32'd1;
        sqdist = 0;
        for (int d = 0; d < 3; d++) begin
            diff   = longint'($signed(c.coord[d])) - longint'($signed(q_coord[d]));
            mag    = (diff < 0) ? -diff : diff;
            sqdist = sqdist + mag * mag;
        end
        r.in_range = (sqdist <= longint'(eps_thr));
        if (r.in_range && c.assigned && c.core && c.cluster < best_id)
            best_id = c.cluster;
        r.hit_index  = c.index;
        r.cluster_id = best_id;
        r.last       = c.last;
        new_query    = c.last;
        return r;
    endfunction

    function automatic dir_row_t reg_row(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] v);
        dir_row_t r;
        r         = '0;
        r.is_cfg  = 1'b1;
        r.cfg_sel = sel;
        r.cfg_val = v;
        return r;
    endfunction

    function automatic dir_row_t cand_row(input int x, input int y, input int z,
                                          input logic [ID_W-1:0] idx,
                                          input logic [ID_W-1:0] clu,
                                          input logic asg, input logic cor,
                                          input logic lst, input logic typed,
                                          input logic hit, input logic [ID_W-1:0] cid);
        dir_row_t r;
        r                    = '0;
        r.cand.coord[0]      = x[CW-1:0];
        r.cand.coord[1]      = y[CW-1:0];
        r.cand.coord[2]      = z[CW-1:0];
        r.cand.index         = idx;
        r.cand.cluster       = clu;
        r.cand.assigned      = asg;
        r.cand.core          = cor;
        r.cand.last          = lst;
        r.typed_in           = typed;
        r.want.in_range      = hit;
        r.want.hit_index     = idx;
        r.want.cluster_id    = cid;
        r.want.last          = lst;
        return r;
    endfunction

    task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (sel)
            REG_QUERY_X:     q_coord[0] = v[CW-1:0];
            REG_QUERY_Y:     q_coord[1] = v[CW-1:0];
            REG_QUERY_Z:     q_coord[2] = v[CW-1:0];
            REG_EPS_SQUARED: eps_thr    = v[EPS_W-1:0];
            REG_QUERY_INDEX: q_index    = v[ID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_candidate(input cand_t c, input logic typed, input result_t fixed_res);
        int      gap;
        result_t want;
        gap = pick_gap(src_calm);
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c.cluster, c.index, c.coord};
        s_tuser  <= {c.core, c.assigned};
        s_tlast  <= c.last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want = predict_neighbor(c);
        pending_results.insert(pending_results.size(), typed ? fixed_res : want);
        items_sent++;
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // result side back-pressure
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
            ready_hold <= ($urandom_range(0, 3) == 0) ? pick_gap(sink_calm) : 0;
        end
    end

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.in_range   = m_tuser[0];
            got.hit_index  = m_tdata[ID_W-1:0];
            got.cluster_id = m_tdata[2*ID_W-1:ID_W];
            got.last       = m_tlast;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: in_range %0b hit_index %0h",
                             got.in_range, got.hit_index,
                             " cluster_id %0h last %0b", got.cluster_id, got.last);
            end else begin
                want = pending_results.pop_front();
                if (got.in_range !== want.in_range || got.hit_index !== want.hit_index ||
                    got.cluster_id !== want.cluster_id || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch exp: in_range %0b hit_index %0h",
                                 want.in_range, want.hit_index,
                                 " cluster_id %0h last %0b", want.cluster_id, want.last);
                        $display("         got: in_range %0b hit_index %0h",
                                 got.in_range, got.hit_index,
                                 " cluster_id %0h last %0b", got.cluster_id, got.last);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        dir_row_t          steps[$];
        cand_t             c;
        logic              cfg_phase;
        logic              noise;
        logic              exact;
        logic              leave_open;
        logic [CW-1:0]     qc[3];
        logic [ID_W-1:0]   qi;
        logic [EPS_W-1:0]  ev;
        longint unsigned   rad;
        longint unsigned   rnd64;
        longint            tmp;
        int                phase;
        int                nq;
        int                len;
        int                pick;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        aresetn   = 1'b0;
        q_coord   = '0;
        eps_thr   = '0;
        q_index   = '0;
        best_id   = 32'd1;
        new_query = 1'b1;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        steps = '{
            // reset values: eps 0, query at origin, starting id 1
            cand_row(0, 0, 0, 32'd5, 32'd0, 1, 1, 0, 1, 1, 32'd0),
            cand_row(1, 0, 0, 32'd6, 32'd0, 1, 1, 1, 1, 0, 32'd0),
            cand_row(-8388608, 8388607, 0, 32'd7, 32'd0, 1, 1, 1, 1, 0, 32'd1),
            reg_row(REG_EPS_SQUARED, EPS_MAX),
            cand_row(-8388608, -8388608, -8388608, 32'hFFFF_FFFE, 32'd7, 1, 1, 0, 1, 1, 32'd1),
            cand_row(8388607, 8388607, 8388607, 32'd0, 32'd0, 0, 1, 0, 1, 1, 32'd1),
            cand_row(0, 0, 0, 32'd1, 32'd0, 1, 0, 0, 1, 1, 32'd1),
            cand_row(0, 0, 0, 32'd2, 32'd0, 1, 1, 1, 1, 1, 32'd0),
            // opposite corner, junk above the coordinate width, index wraps
            reg_row(REG_QUERY_X, 52'h0000000_7FFFFF),
            reg_row(REG_QUERY_Y, 52'hFFFFFFF_800000),
            reg_row(REG_QUERY_Z, 52'h1234567_7FFFFF),
            reg_row(REG_QUERY_INDEX, 52'h00000_FFFFFFFF),
            reg_row(REG_EPS_SQUARED, 52'd0),
            cand_row(-8388608, 8388607, -8388608, 32'd10, 32'd5, 1, 1, 0, 1, 0, 32'd0),
            cand_row(8388607, -8388608, 8388607, 32'd11, 32'd5, 1, 1, 1, 1, 1, 32'd0),
            // largest distance sits exactly on the radius
            reg_row(REG_EPS_SQUARED, 52'h2FFFFFA000003),
            reg_row(REG_QUERY_INDEX, 52'd9),
            cand_row(-8388608, 8388607, -8388608, 32'd12, 32'd3, 1, 1, 0, 1, 1, 32'd3),
            // mid-query index write applies to the next query only
            reg_row(REG_EPS_SQUARED, 52'h2FFFFFA000002),
            reg_row(REG_QUERY_INDEX, 52'd20),
            cand_row(-8388608, 8388607, -8388608, 32'd13, 32'd2, 1, 1, 1, 1, 0, 32'd3),
            cand_row(8388607, -8388608, 8388607, 32'd14, 32'd0, 0, 0, 1, 1, 1, 32'd21),
            reg_row(REG_QUERY_X, 52'd0),
            reg_row(REG_QUERY_Y, 52'd0),
            reg_row(REG_QUERY_Z, 52'd0),
            reg_row(REG_EPS_SQUARED, 52'd100),
            reg_row(REG_QUERY_INDEX, 52'd0),
            cand_row(10, 0, 0, 32'd15, 32'd0, 0, 1, 0, 1, 1, 32'd1),
            cand_row(-3, -4, -9, 32'd16, 32'd0, 1, 1, 0, 0, 0, 32'd0),
            cand_row(6, 8, 0, 32'd17, 32'd0, 1, 1, 1, 0, 0, 32'd0),
            cand_row(0, 0, 0, 32'd18, 32'hFFFF_FFFF, 1, 1, 1, 0, 0, 32'd0)
        };

        cfg_phase = 1'b1;
        foreach (steps[i]) begin
            if (steps[i].is_cfg) begin
                if (!cfg_phase) wait_for_drain();
                write_reg(steps[i].cfg_sel, steps[i].cfg_val);
                cfg_phase = 1'b1;
            end else begin
                send_candidate(steps[i].cand, steps[i].typed_in, steps[i].want);
                cfg_phase = 1'b0;
            end
        end

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            wait_for_drain();
            src_calm  = ($urandom_range(0, 4) == 0);
            sink_calm = ($urandom_range(0, 4) == 0);

            for (int d = 0; d < 3; d++) begin
                pick = $urandom_range(0, 4);
                qc[d] = (pick == 0) ? 24'h800000 : (pick == 1) ? 24'h7FFFFF : CW'($urandom);
            end
            write_reg(REG_QUERY_X, CFG_DATA_W'({$urandom, qc[0]}));
            write_reg(REG_QUERY_Y, CFG_DATA_W'({$urandom, qc[1]}));
            write_reg(REG_QUERY_Z, CFG_DATA_W'({$urandom, qc[2]}));

            rad   = longint'(1) << $urandom_range(0, 23);
            rnd64 = {$urandom, $urandom};
            pick  = $urandom_range(0, 9);
            if (phase == 0 || pick == 0)
                ev = '0;
            else if (phase == 1 || pick == 1)
                ev = EPS_MAX;
            else
                ev = EPS_W'(rnd64 % (3 * rad * rad + 1));
            write_reg(REG_EPS_SQUARED, CFG_DATA_W'(ev));

            pick = $urandom_range(0, 9);
            qi = (pick == 0) ? 32'hFFFF_FFFF : (pick == 1) ? 32'd0 : $urandom;
            write_reg(REG_QUERY_INDEX, CFG_DATA_W'({$urandom, qi}));

            nq         = $urandom_range(2, 8);
            leave_open = ($urandom_range(0, 5) == 0);
            for (int q = 0; q < nq; q++) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
                for (int i = 0; i < len; i++) begin
                    noise = ($urandom_range(0, 9) == 0);
                    exact = ($urandom_range(0, 7) == 0);
                    for (int d = 0; d < 3; d++) begin
                        if (noise) begin
                            c.coord[d] = CW'($urandom);
                        end else if (exact) begin
                            c.coord[d] = q_coord[d];
                        end else begin
                            tmp = longint'($signed(q_coord[d])) +
                                  longint'($urandom_range(0, int'(2 * rad))) - longint'(rad);
                            c.coord[d] = tmp[CW-1:0];
                        end
                    end
                    c.index = $urandom;
                    if (c.index == 32'hFFFF_FFFF) c.index = 32'hFFFF_FFFE;
                    case ($urandom_range(0, 3))
                        0:       c.cluster = $urandom;
                        1:       c.cluster = q_index + 32'd1 - $urandom_range(0, 40);
                        2:       c.cluster = best_id - $urandom_range(0, 3);
                        default: c.cluster = q_index + $urandom_range(0, 40);
                    endcase
                    c.assigned = ($urandom_range(0, 3) != 0);
                    c.core     = ($urandom_range(0, 3) != 0);
                    c.last     = (i == len - 1) && !(q == nq - 1 && leave_open);
                    send_candidate(c, 1'b0, '0);
                end
            end
            phase++;
        end

        wait_for_drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
